// ----- sv/chg_pkg.sv -----
// ----------------------------------------------------------------------------
// chg_pkg
// Shared types, constants and helper functions for the convex hull block.
// ----------------------------------------------------------------------------
package chg_pkg;

   localparam int RESULT_LIMIT = 8;
   localparam int MIN_HULL     = 3;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } point_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [15:0] hull_x;
      logic signed [15:0] hull_y;
      logic               hull_last;
      logic               hull_empty;
      logic [3:0]         hull_count;
   } rsp_type;

   typedef enum logic [1:0] {
      TURN_COL,
      TURN_CW,
      TURN_CCW
   } turn_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_PIV_RD,
      ST_PIV_CMP,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_SWAP_WR2,
      ST_SORT_KEY,
      ST_SORT_KEYW,
      ST_SORT_RD,
      ST_SORT_MUL,
      ST_SORT_DEC,
      ST_SORT_PUT,
      ST_DED_RD0,
      ST_DED_LD0,
      ST_DED_RD,
      ST_DED_MUL,
      ST_DED_DEC,
      ST_DED_LAST,
      ST_STK_RD1,
      ST_STK_A1,
      ST_STK_A2,
      ST_SCAN_RD,
      ST_SCAN_LD,
      ST_SCAN_MUL,
      ST_SCAN_DEC,
      ST_SCAN_POPW,
      ST_EM_INIT,
      ST_EM_RD,
      ST_EM_LD,
      ST_EMPTY
   } state_type;

   // sign of the cross product, positive is clockwise
   function automatic turn_type turn_of(logic signed [33:0] p1, logic signed [33:0] p2);
      logic signed [34:0] v;
      v = 35'(p1) - 35'(p2);
      if (v == '0)
         return TURN_COL;
      else if (!v[34])
         return TURN_CW;
      else
         return TURN_CCW;
   endfunction

   // manhattan length, orders collinear points just like euclidean length
   function automatic logic [17:0] l1_len(point_type a, point_type b);
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic [16:0]        ax;
      logic [16:0]        ay;
      dx = 17'(a.x) - 17'(b.x);
      dy = 17'(a.y) - 17'(b.y);
      ax = dx[16] ? 17'(-dx) : 17'(dx);
      ay = dy[16] ? 17'(-dy) : 17'(dy);
      return 18'(ax) + 18'(ay);
   endfunction

endpackage

// ----- sv/chg_ram.sv -----
// ----------------------------------------------------------------------------
// chg_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/convex_hull_graham_scan.sv -----
// Points load one per cycle while req_ready is high; the closing request starts
// pivot search, insertion sort, collinear pruning and stack scan, after which
// the hull vertices go out. One set at a time.
// Reset clears the state machine, point count and output valid; RAM contents
// need no clearing since every entry is written before it is read.
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// Graham scan convex hull over a small set of integer points held in RAM.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan
   import chg_pkg::*;
#(
   parameter int MAX_POINTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = $bits(point_type);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in, m_ff, m_in, d_ff, d_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, best_ff, best_in;
   logic [3:0]    k_ff, k_in, rc_ff, rc_in;
   point_type     pivot_ff, pivot_in, key_ff, key_in, cur_ff, cur_in;
   point_type     prev_ff, prev_in, top_ff, top_in, sec_ff, sec_in;
   logic signed [33:0] prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic          far_ff, far_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          pt_we, pt_re, st_we, st_re;
   logic [IW-1:0] pt_wa, pt_ra, st_wa, st_ra;
   point_type     pt_wd, st_wd;
   logic [PW-1:0] pt_rd_data, st_rd_data;
   point_type     pt_rd, st_rd;

   logic [CW-1:0] cnt_next, n_m1, m_m1, m_inc, em_addr;
   point_type     tp, tq, tr;
   logic signed [16:0] d1, d2, d3, d4;
   turn_type      turn;
   logic          rsp_free, after;
   point_type     req_pt;

   assign pt_rd  = point_type'(pt_rd_data);
   assign st_rd  = point_type'(st_rd_data);
   assign req_pt = '{x: req.point_x, y: req.point_y};

   chg_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock  (clock),
      .wr_en  (pt_we),
      .wr_addr(pt_wa),
      .wr_data(pt_wd),
      .rd_en  (pt_re),
      .rd_addr(pt_ra),
      .rd_data(pt_rd_data)
   );

   chg_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_stack_ram (
      .clock  (clock),
      .wr_en  (st_we),
      .wr_addr(st_wa),
      .wr_data(st_wd),
      .rd_en  (st_re),
      .rd_addr(st_ra),
      .rd_data(st_rd_data)
   );

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign cnt_next = cnt_ff + CW'(1);
   assign n_m1     = n_ff - CW'(1);
   assign m_m1     = m_ff - CW'(1);
   assign m_inc    = m_ff + CW'(1);
   assign em_addr  = d_ff - CW'(1) - CW'(k_ff);

   // shared turn unit operands
   always_comb begin
      tp = pivot_ff;
      tq = pt_rd;
      tr = key_ff;
      case (state_ff)
         ST_DED_MUL: begin
            tq = prev_ff;
            tr = pt_rd;
         end
         ST_SCAN_MUL: begin
            tp = sec_ff;
            tq = top_ff;
         end
         default: ;
      endcase
   end

   assign d1       = 17'(tq.y) - 17'(tp.y);
   assign d2       = 17'(tr.x) - 17'(tq.x);
   assign d3       = 17'(tq.x) - 17'(tp.x);
   assign d4       = 17'(tr.y) - 17'(tq.y);
   assign prod1_in = d1 * d2;
   assign prod2_in = d3 * d4;
   // key nearer than the element read: key goes first when collinear
   assign far_in   = l1_len(key_ff, pivot_ff) < l1_len(pt_rd, pivot_ff);
   assign turn     = turn_of(prod1_ff, prod2_ff);
   assign after    = (turn == TURN_COL) ? far_ff : (turn != TURN_CCW);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      m_ff     <= m_in;
      d_ff     <= d_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      best_ff  <= best_in;
      k_ff     <= k_in;
      rc_ff    <= rc_in;
      pivot_ff <= pivot_in;
      key_ff   <= key_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      top_ff   <= top_in;
      sec_ff   <= sec_in;
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      far_ff   <= far_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      best_in      = best_ff;
      k_in         = k_ff;
      rc_in        = rc_ff;
      pivot_in     = pivot_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      top_in       = top_ff;
      sec_in       = sec_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pt_we        = 1'b0;
      pt_wa        = '0;
      pt_wd        = req_pt;
      pt_re        = 1'b0;
      pt_ra        = '0;
      st_we        = 1'b0;
      st_wa        = '0;
      st_wd        = key_ff;
      st_re        = 1'b0;
      st_ra        = '0;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (cnt_ff != CW'(MAX_POINTS)) begin
                  pt_we  = 1'b1;
                  pt_wa  = cnt_ff[IW-1:0];
                  cnt_in = cnt_next;
               end
               if (req.last_point) begin
                  n_in   = (cnt_ff != CW'(MAX_POINTS)) ? cnt_next : cnt_ff;
                  cnt_in = '0;
                  i_in   = '0;
                  best_in = '0;
                  state_in = (n_in < CW'(MIN_HULL)) ? ST_EMPTY : ST_PIV_RD;
               end
            end
         end
         ST_PIV_RD: begin
            pt_re    = 1'b1;
            pt_ra    = i_ff;
            state_in = ST_PIV_CMP;
         end
         ST_PIV_CMP: begin
            if (i_ff == '0 || pt_rd.y < pivot_ff.y ||
                (pt_rd.y == pivot_ff.y && pt_rd.x < pivot_ff.x)) begin
               pivot_in = pt_rd;
               best_in  = i_ff;
            end
            if (i_ff == n_m1[IW-1:0]) begin
               state_in = ST_SWAP_RD;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_PIV_RD;
            end
         end
         ST_SWAP_RD: begin
            pt_re    = 1'b1;
            pt_ra    = '0;
            state_in = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            pt_we    = 1'b1;
            pt_wa    = best_ff;
            pt_wd    = pt_rd;
            state_in = ST_SWAP_WR2;
         end
         ST_SWAP_WR2: begin
            pt_we    = 1'b1;
            pt_wa    = '0;
            pt_wd    = pivot_ff;
            i_in     = IW'(2);
            state_in = ST_SORT_KEY;
         end
         ST_SORT_KEY: begin
            pt_re    = 1'b1;
            pt_ra    = i_ff;
            state_in = ST_SORT_KEYW;
         end
         ST_SORT_KEYW: begin
            key_in   = pt_rd;
            j_in     = i_ff;
            state_in = ST_SORT_RD;
         end
         ST_SORT_RD: begin
            pt_re    = 1'b1;
            pt_ra    = j_ff - IW'(1);
            state_in = ST_SORT_MUL;
         end
         ST_SORT_MUL: begin
            cur_in   = pt_rd;
            state_in = ST_SORT_DEC;
         end
         ST_SORT_DEC: begin
            pt_we = 1'b1;
            pt_wa = j_ff;
            if (after) begin
               pt_wd = cur_ff;
               j_in  = j_ff - IW'(1);
               state_in = (j_ff == IW'(2)) ? ST_SORT_PUT : ST_SORT_RD;
            end else begin
               pt_wd = key_ff;
               if (i_ff == n_m1[IW-1:0]) begin
                  state_in = ST_DED_RD0;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_SORT_KEY;
               end
            end
         end
         ST_SORT_PUT: begin
            pt_we = 1'b1;
            pt_wa = IW'(1);
            pt_wd = key_ff;
            if (i_ff == n_m1[IW-1:0]) begin
               state_in = ST_DED_RD0;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_SORT_KEY;
            end
         end
         ST_DED_RD0: begin
            pt_re    = 1'b1;
            pt_ra    = IW'(1);
            m_in     = CW'(1);
            i_in     = IW'(2);
            state_in = ST_DED_LD0;
         end
         ST_DED_LD0: begin
            prev_in  = pt_rd;
            state_in = ST_DED_RD;
         end
         ST_DED_RD: begin
            pt_re    = 1'b1;
            pt_ra    = i_ff;
            state_in = ST_DED_MUL;
         end
         ST_DED_MUL: begin
            cur_in   = pt_rd;
            state_in = ST_DED_DEC;
         end
         ST_DED_DEC: begin
            // keep only the farthest of a collinear run
            if (turn != TURN_COL) begin
               pt_we = 1'b1;
               pt_wa = m_ff[IW-1:0];
               pt_wd = prev_ff;
               m_in  = m_inc;
            end
            prev_in = cur_ff;
            if (i_ff == n_m1[IW-1:0]) begin
               state_in = ST_DED_LAST;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_DED_RD;
            end
         end
         ST_DED_LAST: begin
            pt_we    = 1'b1;
            pt_wa    = m_ff[IW-1:0];
            pt_wd    = prev_ff;
            m_in     = m_inc;
            state_in = (m_inc < CW'(MIN_HULL)) ? ST_EMPTY : ST_STK_RD1;
         end
         ST_STK_RD1: begin
            pt_re    = 1'b1;
            pt_ra    = IW'(1);
            st_we    = 1'b1;
            st_wa    = '0;
            st_wd    = pivot_ff;
            state_in = ST_STK_A1;
         end
         ST_STK_A1: begin
            st_we    = 1'b1;
            st_wa    = IW'(1);
            st_wd    = pt_rd;
            sec_in   = pt_rd;
            pt_re    = 1'b1;
            pt_ra    = IW'(2);
            state_in = ST_STK_A2;
         end
         ST_STK_A2: begin
            st_we    = 1'b1;
            st_wa    = IW'(2);
            st_wd    = pt_rd;
            top_in   = pt_rd;
            d_in     = CW'(MIN_HULL);
            i_in     = IW'(3);
            state_in = (m_ff == CW'(MIN_HULL)) ? ST_EM_INIT : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            pt_re    = 1'b1;
            pt_ra    = i_ff;
            state_in = ST_SCAN_LD;
         end
         ST_SCAN_LD: begin
            key_in   = pt_rd;
            state_in = ST_SCAN_MUL;
         end
         ST_SCAN_MUL: begin
            state_in = ST_SCAN_DEC;
         end
         ST_SCAN_DEC: begin
            if (d_ff > CW'(1) && turn != TURN_CCW) begin
               // pop; if the stack still holds two entries, refetch the new second entry from the stack RAM
               top_in = sec_ff;
               d_in   = d_ff - CW'(1);
               if (d_ff > CW'(2)) begin
                  st_re    = 1'b1;
                  st_ra    = IW'(d_ff - CW'(3));
                  state_in = ST_SCAN_POPW;
               end else begin
                  state_in = ST_SCAN_DEC;
               end
            end else begin
               st_we  = 1'b1;
               st_wa  = d_ff[IW-1:0];
               st_wd  = key_ff;
               sec_in = top_ff;
               top_in = key_ff;
               d_in   = d_ff + CW'(1);
               if (i_ff == m_m1[IW-1:0]) begin
                  state_in = ST_EM_INIT;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_POPW: begin
            sec_in   = st_rd;
            state_in = ST_SCAN_MUL;
         end
         ST_EM_INIT: begin
            rc_in    = (int'(d_ff) > RESULT_LIMIT) ? 4'(RESULT_LIMIT) : 4'(d_ff);
            k_in     = '0;
            state_in = ST_EM_RD;
         end
         ST_EM_RD: begin
            st_re    = 1'b1;
            st_ra    = em_addr[IW-1:0];
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            if (rsp_free) begin
               rsp_in.hull_x     = st_rd.x;
               rsp_in.hull_y     = st_rd.y;
               rsp_in.hull_last  = (k_ff == rc_ff - 4'd1);
               rsp_in.hull_empty = 1'b0;
               rsp_in.hull_count = rc_ff;
               rsp_valid_in      = 1'b1;
               if (k_ff == rc_ff - 4'd1) begin
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = ST_EM_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (rsp_free) begin
               rsp_in.hull_x     = '0;
               rsp_in.hull_y     = '0;
               rsp_in.hull_last  = 1'b1;
               rsp_in.hull_empty = 1'b1;
               rsp_in.hull_count = '0;
               rsp_valid_in      = 1'b1;
               state_in          = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ----- sv/chg_checker.sv -----
// ----------------------------------------------------------------------------
// chg_checker
// Port level checks for the convex hull block, bound to the top level.
// ----------------------------------------------------------------------------
module chg_checker
   import chg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // a closing request starts the hull work, no request is taken right after
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req.last_point |=> !req_ready)
      else $error("request accepted right after a closing request");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.hull_empty |-> rsp.hull_last && rsp.hull_count == 4'd0 &&
         rsp.hull_x == 16'sd0 && rsp.hull_y == 16'sd0)
      else $error("malformed empty hull response");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.hull_empty |-> rsp.hull_count != 4'd0 &&
         rsp.hull_count <= 4'(RESULT_LIMIT))
      else $error("hull count out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

endmodule

bind convex_hull_graham_scan chg_checker u_chg_checker (.*);
